### hw/rtl/tcw_pkg.sv
// shared constants, types and helpers for the text console writer
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ADDR_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int CODE_W = 8;
  localparam int ACT_W  = 2;
  localparam int NIB_W  = 4;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CODE_W-1:0] CH_LAST      = 8'h7F;

  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [CELL_W-1:0] cell_t;

  // cursor update for a put transfer
  typedef struct packed {
    col_t col;
    row_t row;
    logic wr;
    logic scroll;
  } cursor_upd_t;

  function automatic addr_t cell_index(row_t row, col_t col);
    cell_index = ADDR_W'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

### hw/rtl/tcw_screen_ram.sv
// screen cell memory, one write port and one registered read port
module tcw_screen_ram (
  input  logic           clk,
  input  logic           we,
  input  tcw_pkg::addr_t waddr,
  input  tcw_pkg::cell_t wdata,
  input  tcw_pkg::addr_t raddr,
  output tcw_pkg::cell_t rdata
);
  import tcw_pkg::*;

  cell_t mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tcw_cursor.sv
// next cursor position for a put character transfer
module tcw_cursor (
  input  tcw_pkg::col_t       col,
  input  tcw_pkg::row_t       row,
  input  logic [7:0]          char_code,
  output tcw_pkg::cursor_upd_t upd
);
  import tcw_pkg::*;

  logic [COL_W:0] c;
  logic [ROW_W:0] r;
  logic           printable;

  assign printable = (char_code >= CH_SPACE) && (char_code <= CH_LAST);

  always_comb begin
    c = {1'b0, col};
    r = {1'b0, row};
    upd.wr = 1'b0;
    if (char_code == CH_BACKSPACE) begin
      if (col != '0) begin
        c = {1'b0, col} - 1'b1;
      end
    end else if (char_code == CH_TAB) begin
      c = (COL_W + 1)'((int'(col) / TAB_WIDTH) * TAB_WIDTH + TAB_WIDTH);
    end else if (char_code == CH_CR) begin
      c = '0;
    end else if (char_code == CH_LF) begin
      c = '0;
      r = {1'b0, row} + 1'b1;
    end else if (printable) begin
      c = {1'b0, col} + 1'b1;
      upd.wr = 1'b1;
    end
    // wrap past the last column
    if (c >= (COL_W + 1)'(COLUMNS)) begin
      c = '0;
      r = r + 1'b1;
    end
    upd.scroll = (r >= (ROW_W + 1)'(ROWS));
    if (upd.scroll) begin
      r = (ROW_W + 1)'(ROWS - 1);
    end
    upd.col = c[COL_W-1:0];
    upd.row = r[ROW_W-1:0];
  end

endmodule

### hw/rtl/text_console_writer_top.sv
// Text console writer top level: 80x25 cell screen memory with cursor control.
// Put, clear and unused actions give their result in the cycle after the
// transfer, and the next item may follow at once while the output is taken,
// unless a scroll or clear is started; a read passes through the registered
// memory read and the S_READ state before its result. A line feed or wrap
// off the bottom row scrolls the screen through the single memory read and
// write port, one cell a cycle: 1920 copies, a drain of the last copy and 80
// blanks, during which no item is taken. A clear blanks all 2000 cells, and
// after reset the same clearing pass runs before the first item is taken. The
// result of a put or clear is delivered while the memory work runs in the background.
module text_console_writer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcw_pkg::ACT_W-1:0]     action,
  input  logic [tcw_pkg::CODE_W-1:0]    char_code,
  input  logic [tcw_pkg::NIB_W-1:0]     back_color,
  input  logic [tcw_pkg::NIB_W-1:0]     fore_color,
  input  logic [tcw_pkg::ADDR_W-1:0]    cell_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::ADDR_W-1:0]    cursor_offset,
  output logic [tcw_pkg::COL_W-1:0]     cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
  output logic [tcw_pkg::CELL_W-1:0]    cell_data
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SCROLL = 4'b0100,
    S_BLANK  = 4'b1000
  } state_t;

  state_t      state;
  col_t        col;
  row_t        row;
  addr_t       ptr;
  logic        copy_valid;
  addr_t       copy_addr;
  logic        rd_ok;
  cursor_upd_t upd;
  logic        accept;
  logic        ram_we;
  addr_t       ram_waddr;
  cell_t       ram_wdata;
  addr_t       ram_raddr;
  cell_t       ram_rdata;
  addr_t       cur_index;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign cur_index = cell_index(row, col);

  tcw_cursor u_cursor (
    .col       (col),
    .row       (row),
    .char_code (char_code),
    .upd       (upd)
  );

  tcw_screen_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = (state == S_SCROLL) ? addr_t'(ptr + addr_t'(COLUMNS)) : cell_address;

  // copy write-back has priority over the blanking sweep
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = BLANK_CELL;
    if (copy_valid) begin
      ram_we    = 1'b1;
      ram_waddr = copy_addr;
      ram_wdata = ram_rdata;
    end else if (state == S_BLANK) begin
      ram_we = 1'b1;
    end else if (accept && action == ACT_PUT && upd.wr) begin
      ram_we    = 1'b1;
      ram_waddr = cur_index;
      ram_wdata = {back_color, fore_color, char_code};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_BLANK;
      ptr        <= '0;
      col        <= '0;
      row        <= '0;
      copy_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      copy_valid <= 1'b0;
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_PUT: begin
                col           <= upd.col;
                row           <= upd.row;
                out_valid     <= 1'b1;
                cursor_column <= upd.col;
                cursor_row    <= upd.row;
                cursor_offset <= cell_index(upd.row, upd.col);
                cell_data     <= '0;
                if (upd.scroll) begin
                  state <= S_SCROLL;
                  ptr   <= '0;
                end
              end
              ACT_CLEAR: begin
                col           <= '0;
                row           <= '0;
                out_valid     <= 1'b1;
                cursor_column <= '0;
                cursor_row    <= '0;
                cursor_offset <= '0;
                cell_data     <= '0;
                state         <= S_BLANK;
                ptr           <= '0;
              end
              ACT_READ: begin
                rd_ok <= (cell_address < addr_t'(CELL_COUNT));
                state <= S_READ;
              end
              default: begin
                out_valid     <= 1'b1;
                cursor_column <= col;
                cursor_row    <= row;
                cursor_offset <= cur_index;
                cell_data     <= '0;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid     <= 1'b1;
          cursor_column <= col;
          cursor_row    <= row;
          cursor_offset <= cur_index;
          cell_data     <= rd_ok ? ram_rdata : '0;
          state         <= S_IDLE;
        end
        S_SCROLL: begin
          // read one row ahead, write back the next cycle
          copy_valid <= 1'b1;
          copy_addr  <= ptr;
          ptr        <= ptr + 1'b1;
          if (ptr == addr_t'((ROWS - 1) * COLUMNS - 1)) begin
            state <= S_BLANK;
          end
        end
        S_BLANK: begin
          if (!copy_valid) begin
            ptr <= ptr + 1'b1;
            if (ptr == addr_t'(CELL_COUNT - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
